// File: rtl/core/hbf_pkg.sv
// Shared types, widths and constants of the box-filter Hessian response block.
package hbf_pkg;

  // Field widths of the stream items and configuration registers.
  localparam int VAL_W = 22;
  localparam int IDX_W = 7;
  localparam int FS_W = 7;
  localparam int STEP_W = 4;
  localparam int DIM_W = 8;
  localparam int DET_W = 53;
  localparam int POS_W = IDX_W + STEP_W;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 56;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Arithmetic widths of the response datapath.
  localparam int DXX_W = 27;
  localparam int P_W = 2 * DXX_W;
  localparam int SQ_W = 50;
  localparam int COEF_W = 16;
  localparam int Q_W = SQ_W + COEF_W;
  localparam int NUM_W = 69;
  localparam int MAG_W = NUM_W - 1;
  localparam int DEN_W = 27;
  localparam int Q16_SH = 16;

  localparam int DEFAULT_MAX_WIDTH = 128;
  localparam int DEFAULT_MAX_HEIGHT = 128;
  localparam int QUEUE_DEPTH = 4;
  localparam int READ_COUNT = 32;

  // floor(w/3) as (w*43)>>7 holds for every w up to 99.
  localparam int THIRD_MUL = 43;
  localparam int THIRD_SH = 7;

  localparam logic [COEF_W-1:0] COEF_Q16 = 16'd53084;
  localparam logic [MAG_W-1:0] DET_MAX = MAG_W'({52{1'b1}});
  localparam logic [FS_W-1:0] FS_MIN = 7'd9;
  localparam logic [FS_W-1:0] FS_MAX = 7'd99;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef struct packed {
    logic [FS_W-1:0] filter_size;
    logic [STEP_W-1:0] sample_step;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    filter_size: 7'd9, sample_step: 4'd1, image_width: 8'd128, image_height: 8'd128
  };

  typedef struct packed {
    logic mode;
    logic load_ok;
    logic outside;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
  } cmd_t;

  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic lap;
    logic outside;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SETUP, BK_READ, BK_MUL, BK_SCALE, BK_NUM, BK_DIV, BK_OUT
  } bk_state_t;

  typedef enum logic [2:0] {
    DV_IDLE, DV_RUN, DV_FIX, DV_SAT, DV_DONE
  } div_state_t;

endpackage

// File: rtl/core/hessian_box_filter_response.sv
// Top level of the box-filter Hessian determinant block: configuration and output register.
// Each load is written as it is dequeued, so loads stream at one item a cycle unless a query
// holds the back end; an outside query is dequeued and handed over. An inside query is
// dequeued, set up, makes its 32 corner reads through the single store read port, passes the
// multiply, scale and numerator steps and the bit-serial divide by w^4, and is handed over.
// Reset sets w=9, step 1 and a 128x128 image and empties the queue; the store is not cleared.
module hessian_box_filter_response #(
  parameter int MAX_WIDTH = hbf_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = hbf_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [hbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hbf_pkg::S_TDATA_W-1:0]   s_tdata,   // row[6:0], col[13:7], value[35:14]
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [hbf_pkg::M_TDATA_W-1:0]   m_tdata,   // determinant[52:0], laplacian_sign[53]
  output logic                            m_tuser    // outside
);
  import hbf_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic q_full;
  logic q_empty;
  logic res_valid;
  res_t res;
  logic res_take;

  // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FILTER_SIZE:  cfg.filter_size <= cfg_data[FS_W-1:0];
        REG_SAMPLE_STEP:  cfg.sample_step <= cfg_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end scales and classifies each item and drops it into the queue, so while the
  // queue has room the input side keeps taking items as the back end works on an earlier one.
  hbf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  hbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end takes loads and queries in arrival order, so a query always sees
  // every load accepted before it.
  hbf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: a finished result moves here when the slot is free or being
  // emptied, which lets the back end start the next item while this one waits.
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {(M_TDATA_W - DET_W - 1)'(0), res.lap, res.det};
      m_tuser <= res.outside;
    end
  end

endmodule

// File: rtl/core/hbf_queue.sv
// Short command queue between the front and the back of the response block.
module hbf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hbf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output hbf_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import hbf_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);

  cmd_t ent [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0] count;

  assign full = (count == (QPW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + (QPW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPW+1)'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

// File: rtl/core/hbf_front.sv
// Front end: accepts stream items, scales query positions and classifies them.
module hbf_front #(
  parameter int MAX_WIDTH = hbf_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = hbf_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hbf_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  hbf_pkg::cfg_t                   cfg,
  input  logic                            q_full,
  output logic                            push,
  output hbf_pkg::cmd_t                   cmd
);
  import hbf_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CMP_W = $clog2(MAX_DIM) + POS_W;

  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [STEP_W-1:0] step_e;
  logic [POS_W-1:0] r;
  logic [POS_W-1:0] c;
  logic [CMP_W-1:0] eff_h;
  logic [CMP_W-1:0] eff_w;

  assign row = s_tdata[IDX_W-1:0];
  assign col = s_tdata[2*IDX_W-1:IDX_W];

  assign s_tready = !q_full;
  assign push = s_tvalid && !q_full;

  always_comb begin
    step_e = (cfg.sample_step == '0) ? STEP_W'(1) : cfg.sample_step;
    r = POS_W'(row) * POS_W'(step_e);
    c = POS_W'(col) * POS_W'(step_e);
    eff_h = (CMP_W'(cfg.image_height) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                            : CMP_W'(cfg.image_height);
    eff_w = (CMP_W'(cfg.image_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                          : CMP_W'(cfg.image_width);
    cmd.mode = s_tuser;
    cmd.row = row;
    cmd.col = col;
    cmd.value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    cmd.r = r;
    cmd.c = c;
    cmd.load_ok = (CMP_W'(row) < CMP_W'(MAX_HEIGHT)) && (CMP_W'(col) < CMP_W'(MAX_WIDTH));
    cmd.outside = (CMP_W'(r) >= eff_h) || (CMP_W'(c) >= eff_w);
  end

endmodule

// File: rtl/core/hbf_div.sv
// Serial signed floor divider with saturation to the Q16 determinant range.
module hbf_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [hbf_pkg::NUM_W-1:0]   num,
  input  logic [hbf_pkg::DEN_W-1:0]          den,
  output logic                               done,
  output logic signed [hbf_pkg::DET_W-1:0]   det
);
  import hbf_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  div_state_t state, state_next;
  logic neg;
  logic [DEN_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W:0] mag;
  logic [MAG_W:0] magc;
  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_diff;
  logic ge;

  always_comb begin
    rem_sh = {rem, quo[MAG_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge = (rem_sh >= {1'b0, den_r});
    magc = (mag > {1'b0, DET_MAX}) ? {1'b0, DET_MAX} : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          state_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = DV_FIX;
        end
      end
      DV_FIX: state_next = DV_SAT;
      DV_SAT: state_next = DV_DONE;
      DV_DONE: begin
        done = 1'b1;
        state_next = DV_IDLE;
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          neg <= num[NUM_W-1];
          quo <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
          rem <= '0;
          den_r <= den;
          cnt <= '0;
        end
      end
      DV_RUN: begin
        rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo <= {quo[MAG_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
      end
      DV_FIX: begin
        // A negative quotient with a remainder rounds one step further down.
        mag <= {1'b0, quo} + (MAG_W+1)'(neg && (rem != '0));
      end
      DV_SAT: begin
        det <= neg ? -magc[DET_W-1:0] : magc[DET_W-1:0];
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> state == DV_IDLE)
    else $error("divider started while busy");

endmodule

// File: rtl/core/hbf_back.sv
// Back end: integral image store, corner read sequencer and determinant datapath.
module hbf_back #(
  parameter int MAX_WIDTH = hbf_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = hbf_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic          clk,
  input  logic          rst,
  input  hbf_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  hbf_pkg::cmd_t head,
  output logic          pop,
  output logic          res_valid,
  output hbf_pkg::res_t res,
  input  logic          res_take
);
  import hbf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADW = $clog2(DEPTH);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW = $clog2(MAX_DIM) + 9;
  localparam int CNT_W = $clog2(READ_COUNT + 1);
  localparam int TW = VAL_W + 3;
  localparam int LW = FS_W + THIRD_SH - 1;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] bv);
    return (a < bv) ? a : bv;
  endfunction

  bk_state_t state, state_next;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic [ADW-1:0] rd_addr;
  logic [ADW-1:0] wr_addr;
  logic wr_en;

  logic [CNT_W-1:0] cnt;
  logic issue;
  logic rd_valid_d;
  logic zero_d;
  logic [2:0] box_d;
  logic [1:0] crn_d;

  logic [FS_W-1:0] w_sat;
  logic [LW-1:0] l_prod;
  logic [5:0] l_val;
  logic signed [CW-1:0] rs, cs, ls, bs, lhs, ws, l2m1, eh, ew;
  logic [2*FS_W-1:0] w2;
  logic [DEN_W-1:0] w4;

  logic [2:0] box_k;
  logic [1:0] crn_k;
  logic signed [CW-1:0] b_row, b_col, b_nr, b_nc, r1, c1, r2, c2, cr, cc;

  logic signed [TW-1:0] term;
  logic signed [TW-1:0] bsum;
  logic signed [TW-1:0] box_val;
  logic signed [DXX_W-1:0] bx;
  logic signed [DXX_W-1:0] triple;
  logic signed [DXX_W-1:0] dxx, dyy, dxy;
  logic signed [DXX_W:0] lap_sum;
  logic signed [P_W-1:0] p;
  logic signed [2*DXX_W-1:0] sq_full;
  logic [SQ_W-1:0] sq;
  logic [Q_W-1:0] q;
  logic lap;

  logic div_start;
  logic signed [NUM_W-1:0] div_num;
  logic div_done;
  logic signed [DET_W-1:0] div_det;

  // Filter geometry from the configured size.
  always_comb begin
    if (cfg.filter_size < FS_MIN) begin
      w_sat = FS_MIN;
    end else if (cfg.filter_size > FS_MAX) begin
      w_sat = FS_MAX;
    end else begin
      w_sat = cfg.filter_size;
    end
    l_prod = LW'(w_sat) * LW'(THIRD_MUL);
    l_val = l_prod[LW-1:THIRD_SH];
    eh = (CW'(cfg.image_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(cfg.image_height);
    ew = (CW'(cfg.image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg.image_width);
    l2m1 = (ls <<< 1) - ONE;
  end

  // Rectangle of the current box and the corner to read.
  assign box_k = cnt[4:2];
  assign crn_k = cnt[1:0];
  assign issue = (state == BK_READ) && (cnt < CNT_W'(READ_COUNT));

  always_comb begin
    unique case (box_k)
      3'd0: begin b_row = rs - ls + ONE; b_col = cs - bs;      b_nr = l2m1; b_nc = ws;   end
      3'd1: begin b_row = rs - ls + ONE; b_col = cs - lhs;     b_nr = l2m1; b_nc = ls;   end
      3'd2: begin b_row = rs - bs;       b_col = cs - ls + ONE; b_nr = ws;   b_nc = l2m1; end
      3'd3: begin b_row = rs - lhs;      b_col = cs - ls + ONE; b_nr = ls;   b_nc = l2m1; end
      3'd4: begin b_row = rs - ls;       b_col = cs + ONE;      b_nr = ls;   b_nc = ls;   end
      3'd5: begin b_row = rs + ONE;      b_col = cs - ls;       b_nr = ls;   b_nc = ls;   end
      3'd6: begin b_row = rs - ls;       b_col = cs - ls;       b_nr = ls;   b_nc = ls;   end
      3'd7: begin b_row = rs + ONE;      b_col = cs + ONE;      b_nr = ls;   b_nc = ls;   end
      default: begin b_row = rs; b_col = cs; b_nr = ls; b_nc = ls; end
    endcase
    r1 = smin(b_row, eh) - ONE;
    c1 = smin(b_col, ew) - ONE;
    r2 = smin(b_row + b_nr, eh) - ONE;
    c2 = smin(b_col + b_nc, ew) - ONE;
    case (crn_k)
      2'd0: begin cr = r1; cc = c1; end
      2'd1: begin cr = r1; cc = c2; end
      2'd2: begin cr = r2; cc = c1; end
      default: begin cr = r2; cc = c2; end
    endcase
    rd_addr = ADW'(ADW'($unsigned(cr)) * ADW'(MAX_WIDTH) + ADW'($unsigned(cc)));
  end

  assign wr_en = (state == BK_IDLE) && !q_empty && (head.mode == MODE_LOAD) && head.load_ok;
  assign wr_addr = ADW'(ADW'(head.row) * ADW'(MAX_WIDTH) + ADW'(head.col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head.value;
    end
    rd_data <= mem[rd_addr];
  end

  // Box sums: corners one and four add, corners two and three subtract.
  always_comb begin
    term = zero_d ? '0 : TW'($signed({1'b0, rd_data}));
    box_val = bsum + term;
    bx = (box_val < 0) ? '0 : DXX_W'(box_val);
    triple = bx + (bx <<< 1);
    lap_sum = {dxx[DXX_W-1], dxx} + {dyy[DXX_W-1], dyy};
    sq_full = dxy * dxy;
    div_num = (NUM_W'(p) <<< Q16_SH) - $signed(NUM_W'(q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_valid_d <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid_d <= issue;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.mode == MODE_QUERY) begin
            state_next = head.outside ? BK_OUT : BK_SETUP;
          end
        end
      end
      BK_SETUP: state_next = BK_READ;
      BK_READ: begin
        if (cnt == CNT_W'(READ_COUNT)) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL: state_next = BK_SCALE;
      BK_SCALE: state_next = BK_NUM;
      BK_NUM: begin
        div_start = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    zero_d <= (cr < 0) || (cc < 0);
    box_d <= box_k;
    crn_d <= crn_k;
    case (state)
      BK_IDLE: begin
        rs <= CW'(head.r);
        cs <= CW'(head.c);
        res <= '{det: '0, lap: 1'b0, outside: 1'b1};
      end
      BK_SETUP: begin
        ws <= CW'(w_sat);
        ls <= CW'(l_val);
        lhs <= CW'(l_val >> 1);
        bs <= CW'((w_sat - FS_W'(1)) >> 1);
        w2 <= (2*FS_W)'(w_sat) * (2*FS_W)'(w_sat);
        cnt <= '0;
        dxx <= '0;
        dyy <= '0;
        dxy <= '0;
      end
      BK_READ: begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == '0) begin
          w4 <= DEN_W'(w2 * w2);
        end
        if (rd_valid_d) begin
          case (crn_d)
            2'd0: bsum <= term;
            2'd3: begin
              case (box_d) inside
                3'd0: dxx <= dxx + bx;
                3'd1: dxx <= dxx - triple;
                3'd2: dyy <= dyy + bx;
                3'd3: dyy <= dyy - triple;
                3'd4, 3'd5: dxy <= dxy + bx;
                default: dxy <= dxy - bx;
              endcase
            end
            default: bsum <= bsum - term;
          endcase
        end
      end
      BK_MUL: begin
        p <= dxx * dyy;
        sq <= sq_full[SQ_W-1:0];
        lap <= !lap_sum[DXX_W];
      end
      BK_SCALE: begin
        q <= Q_W'(sq) * Q_W'(COEF_Q16);
      end
      BK_DIV: begin
        if (div_done) begin
          res <= '{det: div_det, lap: lap, outside: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  hbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (w4),
    .done  (div_done),
    .det   (div_det)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == BK_DIV)
    else $error("quotient returned outside the divide phase");

endmodule

// File: sim/hessian_box_filter_response_test.sv
// Self-checking testbench for the box-filter Hessian determinant block.
module hessian_box_filter_response_test;
  import hbf_pkg::*;

  // Store and register geometry as seen by the block.
  localparam int STORE_ROWS = 128;
  localparam int STORE_COLS = 128;
  localparam int SETTLE_CYCLES = 150;
  localparam int ITEM_TARGET = 1900;
  localparam int MAX_GAP = 12;

  // One expected result: the determinant, the Laplacian sign and the outside flag.
  typedef struct {
    logic signed [DET_W-1:0] det;
    logic lap;
    logic outside;
  } response_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  hessian_box_filter_response dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Shadow copy of the integral store and of the four registers.
  logic [VAL_W-1:0] shadow_store [STORE_ROWS*STORE_COLS];
  logic [FS_W-1:0] shadow_fs;
  logic [STEP_W-1:0] shadow_step;
  logic [DIM_W-1:0] shadow_w;
  logic [DIM_W-1:0] shadow_h;

  // Integral image under construction while a region is loaded.
  int integral_acc [STORE_ROWS][STORE_COLS];

  // Responses predicted for accepted queries, oldest first.
  response_t pending_responses[$];

  int errors;
  int loads_sent;
  int queries_sent;
  int outside_seen;
  int inside_seen;
  int items_sent;

  // When set, neither side inserts idle cycles.
  bit no_idle;

  // Effective image size, as the block clamps it.
  int eff_w;
  int eff_h;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  // Corners above or left of the image read as zero.
  function automatic longint corner_read(int r, int c);
    if (r < 0 || c < 0 || r >= STORE_ROWS || c >= STORE_COLS)
      return 0;
    return longint'(shadow_store[r*STORE_COLS + c]);
  endfunction

  // Rectangle sum with every corner clipped to the image; negative sums become zero.
  function automatic longint rect_sum(int row, int col, int rows, int cols);
    int r1, c1, r2, c2;
    longint s;
    r1 = imin(row, eff_h) - 1;
    c1 = imin(col, eff_w) - 1;
    r2 = imin(row + rows, eff_h) - 1;
    c2 = imin(col + cols, eff_w) - 1;
    s = corner_read(r1, c1) - corner_read(r1, c2) - corner_read(r2, c1) + corner_read(r2, c2);
    return s > 0 ? s : 0;
  endfunction

  function automatic void floor_divide(input longint n, input longint d,
                                       output longint quo, output longint rem);
    quo = n / d;
    rem = n % d;
    if (rem < 0) begin
      quo = quo - 1;
      rem = rem + d;
    end
  endfunction

  // Predicts the response of one query at grid indices (grow, gcol).
  function automatic response_t hessian_response(int grow, int gcol);
    int step, r, c, w, l, b;
    longint dxx, dyy, dxy, den, p, q, pq, pr, tq, tr, det;
    response_t res;
    eff_w = shadow_w > STORE_COLS ? STORE_COLS : int'(shadow_w);
    eff_h = shadow_h > STORE_ROWS ? STORE_ROWS : int'(shadow_h);
    step = shadow_step == 0 ? 1 : int'(shadow_step);
    r = grow * step;
    c = gcol * step;
    if (r >= eff_h || c >= eff_w) begin
      res.det = '0;
      res.lap = 1'b0;
      res.outside = 1'b1;
      return res;
    end
    w = int'(shadow_fs);
    if (w < 9) w = 9;
    if (w > 99) w = 99;
    l = w / 3;
    b = (w - 1) / 2;
    dxx = rect_sum(r - l + 1, c - b, 2*l - 1, w) - rect_sum(r - l + 1, c - l/2, 2*l - 1, l) * 3;
    dyy = rect_sum(r - b, c - l + 1, w, 2*l - 1) - rect_sum(r - l/2, c - l + 1, l, 2*l - 1) * 3;
    dxy = rect_sum(r - l, c + 1, l, l) + rect_sum(r + 1, c - l, l, l)
        - rect_sum(r - l, c - l, l, l) - rect_sum(r + 1, c + 1, l, l);
    den = longint'(w) * w * w * w;
    p = dxx * dyy;
    q = longint'(COEF_Q16) * dxy * dxy;
    floor_divide(p, den, pq, pr);
    floor_divide(pr * 65536 - q, den, tq, tr);
    det = pq * 65536 + tq;
    if (det > longint'(DET_MAX)) det = longint'(DET_MAX);
    if (det < -longint'(DET_MAX)) det = -longint'(DET_MAX);
    res.det = det[DET_W-1:0];
    res.lap = (dxx + dyy >= 0);
    res.outside = 1'b0;
    return res;
  endfunction

  // Clock: period of 10 units.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #40_000_000;
    $display("Timeout at %0t with %0d responses still pending", $time, pending_responses.size());
    $display("TEST FAILED");
    $finish;
  end

  // Receiving side: random stalls on m_tready and a field-by-field compare of every
  // accepted item against the oldest prediction.
  initial begin : response_checker
    int stall;
    response_t want;
    logic signed [DET_W-1:0] got_det;
    m_tready = 1'b0;
    stall = draw_gap();
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_det = m_tdata[DET_W-1:0];
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected item det=%0d lap=%0b outside=%0b",
                   $time, got_det, m_tdata[DET_W], m_tuser);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          if (got_det !== want.det) begin
            $display("%0t: determinant expected %0d, got %0d", $time, want.det, got_det);
            errors++;
          end
          if (m_tdata[DET_W] !== want.lap) begin
            $display("%0t: laplacian_sign expected %0b, got %0b", $time, want.lap, m_tdata[DET_W]);
            errors++;
          end
          if (m_tuser !== want.outside) begin
            $display("%0t: outside expected %0b, got %0b", $time, want.outside, m_tuser);
            errors++;
          end
          if (want.outside) outside_seen++;
          else inside_seen++;
        end
        stall = draw_gap();
      end
      // Hold ready low for the drawn number of cycles, then raise it until an item moves.
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Sends one item and updates the prediction once the block takes it. The valid is
  // dropped only when a gap follows, so a back-to-back item keeps it high.
  task automatic send_item(input logic mode, input int row, input int col, input int value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, value[VAL_W-1:0], col[IDX_W-1:0], row[IDX_W-1:0]};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (mode == MODE_LOAD) begin
      shadow_store[row*STORE_COLS + col] = value[VAL_W-1:0];
      loads_sent++;
    end else begin
      pending_responses.push_back(hessian_response(row, col));
      queries_sent++;
    end
  endtask

  // Waits until every predicted response has come out and the block has gone quiet.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only after drain().
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FILTER_SIZE: shadow_fs = data[FS_W-1:0];
      REG_SAMPLE_STEP: shadow_step = data[STEP_W-1:0];
      REG_IMAGE_WIDTH: shadow_w = data[DIM_W-1:0];
      default: shadow_h = data[DIM_W-1:0];
    endcase
  endtask

  task automatic set_geometry(input int fs, input int step, input int wid, input int hgt);
    drain();
    write_reg(REG_FILTER_SIZE, fs);
    write_reg(REG_SAMPLE_STEP, step);
    write_reg(REG_IMAGE_WIDTH, wid);
    write_reg(REG_IMAGE_HEIGHT, hgt);
  endtask

  // Loads a true integral image of random pixels 0..pix_max over rows x cols.
  // With noise set it loads raw random words 0..65535 instead, so that
  // rectangle sums can turn negative.
  task automatic load_region(input int rows, input int cols, input int pix_max, input bit noise);
    int pix, v;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        pix = $urandom_range(0, pix_max);
        integral_acc[r][c] = pix + (r > 0 ? integral_acc[r-1][c] : 0)
                           + (c > 0 ? integral_acc[r][c-1] : 0)
                           - (r > 0 && c > 0 ? integral_acc[r-1][c-1] : 0);
        v = noise ? $urandom_range(0, 65535) : integral_acc[r][c];
        send_item(MODE_LOAD, r, c, v);
      end
    end
  endtask

  // Random queries; most land inside the image, some anywhere in the grid.
  task automatic run_queries(input int count);
    int stp, gr, gc;
    stp = shadow_step == 0 ? 1 : int'(shadow_step);
    for (int i = 0; i < count; i++) begin
      eff_w = shadow_w > STORE_COLS ? STORE_COLS : int'(shadow_w);
      eff_h = shadow_h > STORE_ROWS ? STORE_ROWS : int'(shadow_h);
      if ($urandom_range(0, 99) < 15 || eff_w == 0 || eff_h == 0) begin
        gr = $urandom_range(0, 127);
        gc = $urandom_range(0, 127);
      end else begin
        gr = $urandom_range(0, (eff_h - 1) / stp);
        gc = $urandom_range(0, (eff_w - 1) / stp);
      end
      send_item(MODE_QUERY, gr, gc, $urandom);
    end
  endtask

  // Extremes of every field, corner positions, clamped sizes, step zero and a zero-size image.
  task automatic test_directed();
    set_geometry(9, 1, 8, 8);
    // Top and bottom of the word range; (0,0) is then overwritten by the real image and (127,127) by a zero load.
    send_item(MODE_LOAD, 127, 127, 4194303);
    send_item(MODE_LOAD, 0, 0, 4194303);
    send_item(MODE_LOAD, 85, 42, 0);
    send_item(MODE_LOAD, 42, 85, 2796202);
    load_region(8, 8, 255, 0);
    send_item(MODE_LOAD, 127, 127, 0);
    send_item(MODE_QUERY, 0, 0, 0);
    send_item(MODE_QUERY, 7, 7, 4194303);
    send_item(MODE_QUERY, 3, 4, 0);
    send_item(MODE_QUERY, 8, 0, 0);
    send_item(MODE_QUERY, 0, 8, 0);
    send_item(MODE_QUERY, 127, 127, 0);
    // Sizes below and above the legal range clamp; 10 is not a multiple of three.
    set_geometry(0, 0, 8, 8);
    send_item(MODE_QUERY, 4, 4, 0);
    send_item(MODE_QUERY, 7, 0, 0);
    set_geometry(127, 15, 8, 8);
    send_item(MODE_QUERY, 0, 0, 0);
    send_item(MODE_QUERY, 1, 0, 0);
    set_geometry(10, 2, 8, 8);
    send_item(MODE_QUERY, 3, 3, 0);
    send_item(MODE_QUERY, 2, 1, 0);
    // A zero-size image makes every query outside.
    set_geometry(9, 1, 0, 8);
    send_item(MODE_QUERY, 0, 0, 0);
    set_geometry(9, 1, 8, 0);
    send_item(MODE_QUERY, 0, 0, 0);
  endtask

  task automatic test_filter_sizes();
    int sizes[10] = '{9, 15, 21, 27, 33, 51, 75, 99, 14, 100};
    set_geometry(9, 1, 20, 20);
    load_region(20, 20, 255, 0);
    foreach (sizes[i]) begin
      set_geometry(sizes[i], $urandom_range(1, 3), 20, 20);
      run_queries(14);
    end
  endtask

  task automatic test_sample_steps();
    for (int s = 0; s < 16; s += (s < 8 ? 1 : 7)) begin
      set_geometry(9 + 6 * $urandom_range(0, 5), s, 20, 20);
      run_queries(10);
    end
  endtask

  // Wide and tall strips, including width and height values above the store size.
  task automatic test_image_shapes();
    set_geometry(9, 1, 128, 2);
    load_region(2, 128, 255, 0);
    run_queries(20);
    set_geometry(99, 4, 255, 1);
    run_queries(15);
    set_geometry(9, 1, 2, 128);
    load_region(128, 2, 255, 0);
    run_queries(20);
    set_geometry(27, 8, 1, 200);
    run_queries(15);
  endtask

  // Raw, non-monotone words, so rectangle sums go negative and are clamped.
  task automatic test_noise_image();
    set_geometry(15, 1, 16, 16);
    load_region(16, 16, 0, 1);
    run_queries(30);
    set_geometry(33, 2, 16, 16);
    run_queries(20);
  endtask

  // Random settings on small images; a stretch with no idling on either side.
  task automatic test_random_mix();
    int dim_w, dim_h;
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      dim_w = $urandom_range(1, 12);
      dim_h = $urandom_range(1, 12);
      set_geometry(3 * $urandom_range(3, 33), $urandom_range(0, 8), dim_w, dim_h);
      load_region(dim_h, dim_w, $urandom_range(0, 1) ? 255 : $urandom_range(0, 20), 0);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 5) == 0)
          send_item(MODE_LOAD, $urandom_range(0, dim_h - 1), $urandom_range(0, dim_w - 1),
                     $urandom_range(0, 40000));
        else
          run_queries(1);
      end
    end
    no_idle = 0;
  endtask

  initial begin
    errors = 0;
    loads_sent = 0;
    queries_sent = 0;
    outside_seen = 0;
    inside_seen = 0;
    items_sent = 0;
    no_idle = 0;
    shadow_fs = 7'd9;
    shadow_step = 4'd1;
    shadow_w = 8'd128;
    shadow_h = 8'd128;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_LOAD;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_filter_sizes();
    test_sample_steps();
    test_image_shapes();
    test_noise_image();
    test_random_mix();
    drain();

    $display("Sent %0d integral words and %0d queries over many register settings.",
             loads_sent, queries_sent);
    $display("Checked %0d responses inside the image and %0d outside; %0d mismatches.",
             inside_seen, outside_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hbf_pkg.sv
rtl/core/hbf_queue.sv
rtl/core/hbf_front.sv
rtl/core/hbf_div.sv
rtl/core/hbf_back.sv
rtl/core/hessian_box_filter_response.sv
sim/hessian_box_filter_response_test.sv
